[rtl/core/gra_pkg.sv]
package gra_pkg;

  // fixed-point formats
  localparam int IN_FRAC   = 12;
  localparam int WORK_FRAC = 24;

  // field widths
  localparam int X_W   = 16;
  localparam int AMP_W = 17;

  // working widths at the default formats
  localparam int XX_W   = 32;  // x*x, WORK_FRAC fraction bits
  localparam int A_W    = 33;  // a = x*x - 1, signed
  localparam int AMAG_W = 32;  // |a|
  localparam int YW_W   = 28;  // y at WORK_FRAC fraction bits
  localparam int RADM_W = 65;  // a*a + y*y
  localparam int M_W    = 33;  // m
  localparam int B_W    = 34;  // b and m + a
  localparam int RADR_W = 58;  // (m + a) * 2^W
  localparam int R_W    = 29;  // r
  localparam int S_W    = 29;  // s = 1.414x
  localparam int SUM_W  = 30;  // s + r, |s - r|
  localparam int SQ_W   = 60;  // squared sum or difference
  localparam int DEN_W  = 61;  // numerator and denominator
  localparam int Q_W    = 33;  // ratio with 32 fraction bits

  // 1414 * 2^(W-IF) / 1000 split into integer part and remainder
  localparam int S_MUL = 1414 * (1 << (WORK_FRAC - IN_FRAC));
  localparam int S_INT = S_MUL / 1000;
  localparam int S_REM = S_MUL % 1000;
  localparam int RECIP_SH = 36;
  localparam logic [26:0] RECIP = 27'(((64'd1 << RECIP_SH) + 64'd999) / 64'd1000);

  localparam logic [XX_W:0] ONE_W = (XX_W+1)'(1) << WORK_FRAC;
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1) << 16;

endpackage

[rtl/core/gra_sqrt_pipe.sv]
module gra_sqrt_pipe
  import gra_pkg::*;
#(
  parameter int RAD_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [RAD_W-1:0]           in_rad,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [(RAD_W+1)/2-1:0]     out_root,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  logic              v_r    [1:ROOT_W];
  logic [PAD_W-1:0]  rad_r  [1:ROOT_W];
  logic [REM_W-1:0]  rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0] root_r [1:ROOT_W];
  logic [SIDE_W-1:0] side_r [1:ROOT_W];

  // one root bit per stage, restoring form
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              v_src;
    logic [PAD_W-1:0]  rad_src;
    logic [REM_W-1:0]  rem_src;
    logic [ROOT_W-1:0] root_src;
    logic [SIDE_W-1:0] side_src;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fit;

    if (i == 0) begin : g_first
      assign v_src    = in_valid;
      assign rad_src  = PAD_W'(in_rad);
      assign rem_src  = '0;
      assign root_src = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign v_src    = v_r[i];
      assign rad_src  = rad_r[i];
      assign rem_src  = rem_r[i];
      assign root_src = root_r[i];
      assign side_src = side_r[i];
    end

    assign rem_sh = {rem_src[REM_W-3:0], rad_src[PAD_W-1:PAD_W-2]};
    assign trial  = {root_src, 2'b01};
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (ce) begin
        v_r[i+1] <= v_src;
      end
      if (ce) begin
        rad_r[i+1]  <= {rad_src[PAD_W-3:0], 2'b00};
        rem_r[i+1]  <= fit ? (rem_sh - trial) : rem_sh;
        root_r[i+1] <= {root_src[ROOT_W-2:0], fit};
        side_r[i+1] <= side_src;
      end
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule

[rtl/core/gra_div_pipe.sv]
module gra_div_pipe
  import gra_pkg::*;
#(
  parameter int D_W    = 8,
  parameter int Q_BITS = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [D_W-1:0]    in_num,
  input  logic [D_W-1:0]    in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_BITS-1:0] out_quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              v_r    [1:Q_BITS];
  logic [D_W:0]      rem_r  [1:Q_BITS];
  logic [D_W-1:0]    den_r  [1:Q_BITS];
  logic [Q_BITS-1:0] quot_r [1:Q_BITS];
  logic [SIDE_W-1:0] side_r [1:Q_BITS];

  // one quotient bit per stage, restoring form
  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    logic              v_src;
    logic [D_W:0]      rem_src;
    logic [D_W-1:0]    den_src;
    logic [Q_BITS-1:0] quot_src;
    logic [SIDE_W-1:0] side_src;
    logic              fit;
    logic [D_W:0]      diff;

    if (i == 0) begin : g_first
      assign v_src    = in_valid;
      assign rem_src  = {1'b0, in_num};
      assign den_src  = in_den;
      assign quot_src = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign v_src    = v_r[i];
      assign rem_src  = rem_r[i];
      assign den_src  = den_r[i];
      assign quot_src = quot_r[i];
      assign side_src = side_r[i];
    end

    assign fit  = (rem_src >= {1'b0, den_src});
    assign diff = fit ? (rem_src - {1'b0, den_src}) : rem_src;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (ce) begin
        v_r[i+1] <= v_src;
      end
      if (ce) begin
        rem_r[i+1]  <= {diff[D_W-1:0], 1'b0};
        den_r[i+1]  <= den_src;
        quot_r[i+1] <= {quot_src[Q_BITS-2:0], fit};
        side_r[i+1] <= side_src;
      end
    end
  end

  assign out_valid = v_r[Q_BITS];
  assign out_quot  = quot_r[Q_BITS];
  assign out_side  = side_r[Q_BITS];

endmodule

[rtl/core/grazing_reflectivity_amplitude_unit.sv]
// Grazing-incidence reflectivity amplitude. Each input beat carries a
// normalized grazing angle x and an absorption ratio y (unsigned Q4.12);
// each output beat carries floor(sqrt(R)) in unsigned Q1.16, one result
// per input, in order. The unit takes one beat per clock when not stalled;
// a beat passes to the output register through four stages of squaring
// and scaling, a 33-stage root for m, one stage for b and m + a, a
// 29-stage root for r, three stages forming the numerator and denominator,
// a 33-stage divider and a 17-stage final root, each root or divider
// stage settling one result bit. A skid register at the output keeps input
// accepted while one result waits; the pipeline stalls only when both hold.
module grazing_reflectivity_amplitude_unit
  import gra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // angle_ratio [15:0], absorb_ratio [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // amplitude [16:0], zero fill [23:17]
);

  logic ce;

  logic [X_W-1:0] in_x;
  logic [X_W-1:0] in_y;

  logic                v1_r;
  logic [XX_W-1:0]     xx1_r;
  logic [S_W-1:0]      xi1_r;
  logic [25:0]         xr1_r;
  logic [X_W-1:0]      y1_r;

  logic                v2_r;
  logic signed [A_W-1:0] a2_r;
  logic [AMAG_W-1:0]   amag2_r;
  logic [YW_W-1:0]     yw2_r;
  logic [S_W-1:0]      xi2_r;
  logic [52:0]         t2_r;

  logic                v3_r;
  logic [63:0]         asq3_r;
  logic [55:0]         ysq3_r;
  logic signed [A_W-1:0] a3_r;
  logic [S_W-1:0]      s3_r;

  logic                v4_r;
  logic [RADM_W-1:0]   rad4_r;
  logic signed [A_W-1:0] a4_r;
  logic [S_W-1:0]      s4_r;

  logic                m_v;
  logic [M_W-1:0]      m_root;
  logic [A_W+S_W-1:0]  m_side;
  logic signed [A_W-1:0] m_a;
  logic signed [B_W:0] b_full;
  logic signed [B_W:0] mpa_full;

  logic                v5_r;
  logic [B_W-1:0]      b5_r;
  logic [B_W-1:0]      mpa5_r;
  logic [S_W-1:0]      s5_r;

  logic                r_v;
  logic [R_W-1:0]      r_root;
  logic [B_W+S_W-1:0]  r_side;
  logic [S_W-1:0]      r_s;

  logic                v6_r;
  logic [SUM_W-1:0]    dif6_r;
  logic [SUM_W-1:0]    sum6_r;
  logic [B_W-1:0]      b6_r;

  logic                v7_r;
  logic [SQ_W-1:0]     dsq7_r;
  logic [SQ_W-1:0]     ssq7_r;
  logic [B_W-1:0]      b7_r;

  logic                v8_r;
  logic [DEN_W-1:0]    num8_r;
  logic [DEN_W-1:0]    den8_r;
  logic                zero8_r;

  logic                q_v;
  logic [Q_W-1:0]      q_quot;
  logic                q_zero;

  logic                f_v;
  logic [AMP_W-1:0]    f_root;
  logic                f_zero;
  logic [AMP_W-1:0]    amp;

  logic                out_v_r;
  logic [AMP_W-1:0]    out_d_r;
  logic                skid_v_r;
  logic [AMP_W-1:0]    skid_d_r;

  assign ce        = !skid_v_r;
  assign in_tready = ce;
  assign in_x      = in_tdata[15:0];
  assign in_y      = in_tdata[31:16];

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= m_v;
      v6_r <= r_v;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // squares and scaled products of the inputs
  always_ff @(posedge clk) begin
    if (ce) begin
      // stage 1: x*x and the two parts of 1.414x
      xx1_r <= XX_W'(in_x * in_x);
      xi1_r <= S_W'(in_x * S_W'(S_INT));
      xr1_r <= 26'(in_x * 26'(S_REM));
      y1_r  <= in_y;
      // stage 2: a = x*x - 1 and its magnitude
      a2_r    <= A_W'($signed({1'b0, xx1_r}) - $signed(ONE_W));
      amag2_r <= ({1'b0, xx1_r} >= ONE_W) ? AMAG_W'({1'b0, xx1_r} - ONE_W)
                                          : AMAG_W'(ONE_W - {1'b0, xx1_r});
      yw2_r   <= {y1_r, (YW_W-X_W)'(0)};
      xi2_r   <= xi1_r;
      t2_r    <= 53'(xr1_r * RECIP);
      // stage 3: squares, and s from the reciprocal product
      asq3_r <= amag2_r * amag2_r;
      ysq3_r <= yw2_r * yw2_r;
      a3_r   <= a2_r;
      s3_r   <= S_W'(xi2_r + S_W'(t2_r >> RECIP_SH));
      // stage 4: a*a + y*y
      rad4_r <= {1'b0, asq3_r} + RADM_W'(ysq3_r);
      a4_r   <= a3_r;
      s4_r   <= s3_r;
    end
  end

  gra_sqrt_pipe #(
    .RAD_W  (RADM_W),
    .SIDE_W (A_W + S_W)
  ) u_sqrt_m (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v4_r),
    .in_rad    (rad4_r),
    .in_side   ({a4_r, s4_r}),
    .out_valid (m_v),
    .out_root  (m_root),
    .out_side  (m_side)
  );

  // b = m - a and m + a, both non-negative
  assign m_a      = $signed(m_side[A_W+S_W-1:S_W]);
  assign b_full   = $signed({2'b00, m_root}) - (B_W+1)'(m_a);
  assign mpa_full = $signed({2'b00, m_root}) + (B_W+1)'(m_a);

  always_ff @(posedge clk) begin
    if (ce) begin
      b5_r   <= b_full[B_W-1:0];
      mpa5_r <= mpa_full[B_W-1:0];
      s5_r   <= m_side[S_W-1:0];
    end
  end

  gra_sqrt_pipe #(
    .RAD_W  (RADR_W),
    .SIDE_W (B_W + S_W)
  ) u_sqrt_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v5_r),
    .in_rad    ({mpa5_r, (RADR_W-B_W)'(0)}),
    .in_side   ({b5_r, s5_r}),
    .out_valid (r_v),
    .out_root  (r_root),
    .out_side  (r_side)
  );

  assign r_s = r_side[S_W-1:0];

  // numerator and denominator
  always_ff @(posedge clk) begin
    if (ce) begin
      dif6_r  <= (r_s >= S_W'(r_root)) ? SUM_W'(r_s - S_W'(r_root))
                                      : SUM_W'(S_W'(r_root) - r_s);
      sum6_r  <= SUM_W'(r_s) + SUM_W'(r_root);
      b6_r    <= r_side[B_W+S_W-1:S_W];
      dsq7_r  <= dif6_r * dif6_r;
      ssq7_r  <= sum6_r * sum6_r;
      b7_r    <= b6_r;
      num8_r  <= DEN_W'(dsq7_r) + DEN_W'({b7_r, (RADR_W-B_W)'(0)});
      den8_r  <= DEN_W'(ssq7_r) + DEN_W'({b7_r, (RADR_W-B_W)'(0)});
      zero8_r <= (ssq7_r == '0) && (b7_r == '0);
    end
  end

  gra_div_pipe #(
    .D_W    (DEN_W),
    .Q_BITS (Q_W),
    .SIDE_W (1)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v8_r),
    .in_num    (num8_r),
    .in_den    (den8_r),
    .in_side   (zero8_r),
    .out_valid (q_v),
    .out_quot  (q_quot),
    .out_side  (q_zero)
  );

  gra_sqrt_pipe #(
    .RAD_W  (Q_W),
    .SIDE_W (1)
  ) u_sqrt_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (q_v),
    .in_rad    (q_quot),
    .in_side   (q_zero),
    .out_valid (f_v),
    .out_root  (f_root),
    .out_side  (f_zero)
  );

  // zero denominator reads as full reflection
  assign amp = f_zero ? AMP_ONE : f_root;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= f_v;
      end
    end else if (f_v && ce) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_d_r <= skid_v_r ? skid_d_r : amp;
    end else if (f_v && ce) begin
      skid_d_r <= amp;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(24-AMP_W)'(0), out_d_r};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat while output register is empty");
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && $past(out_tvalid && !out_tready)))
    else $error("input stalled without a held output beat");
  a_amp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:0] <= AMP_ONE))
    else $error("amplitude above one");
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> !skid_v_r)
    else $error("skid beat not moved on");
`endif

endmodule

[test/grazing_reflectivity_amplitude_unit_tb.sv]
`timescale 1ns / 1ps

module grazing_reflectivity_amplitude_unit_tb;
  import gra_pkg::*;

  localparam int RANDOM_BEATS = 950;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [X_W-1:0]   angle;
    logic [X_W-1:0]   absorb;
    bit               typed;
    logic [AMP_W-1:0] amp;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // angle_ratio [15:0], absorb_ratio [31:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // amplitude [16:0], zero fill [23:17]

  logic [AMP_W-1:0] amp_queue[$];
  int               errors;
  int               idle_cycles;
  int               beats_out;

  grazing_reflectivity_amplitude_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor square root of a 128-bit value
  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [63:0]  res;
    logic [63:0]  c;
    res = '0;
    for (int bitpos = 63; bitpos >= 0; bitpos--) begin
      c = res | (64'd1 << bitpos);
      if ({64'd0, c} * {64'd0, c} <= n) res = c;
    end
    return res;
  endfunction

  // expected amplitude for one angle and absorption pair
  function automatic logic [AMP_W-1:0] calc_amplitude(logic [15:0] x, logic [15:0] y);
    logic signed [127:0] a;
    logic [127:0] amag, yw, m, b, mpa, r, s, dif, sum, num, den, q;
    a    = $signed({96'd0, 32'(x) * 32'(x)}) - (128'sd1 <<< WORK_FRAC);
    amag = (a < 0) ? -a : a;
    yw   = {112'd0, y} << (WORK_FRAC - IN_FRAC);
    m    = {64'd0, root_floor(amag * amag + yw * yw)};
    b    = m - a;
    mpa  = m + a;
    r    = {64'd0, root_floor(mpa << WORK_FRAC)};
    s    = (({112'd0, x} * 1414) << WORK_FRAC >> IN_FRAC) / 1000;
    dif  = (s >= r) ? s - r : r - s;
    sum  = s + r;
    num  = dif * dif + (b << WORK_FRAC);
    den  = sum * sum + (b << WORK_FRAC);
    if (den == 0) return AMP_ONE;
    q = (num << 32) / den;
    return AMP_W'(root_floor(q));
  endfunction

  task automatic report_mismatch(string what, logic [AMP_W-1:0] got, logic [AMP_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one beat after a random gap, record its expected amplitude on acceptance
  task automatic send_beat(logic [15:0] x, logic [15:0] y, bit typed, logic [AMP_W-1:0] amp);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    amp_queue.push_back(typed ? amp : calc_amplitude(x, y));
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    bit held;
    out_tready <= 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && beats_out >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_out <= beats_out + 1;
      if (amp_queue.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[AMP_W-1:0], '0);
      end else begin
        logic [AMP_W-1:0] want;
        want = amp_queue.pop_front();
        if (out_tdata[AMP_W-1:0] !== want) begin
          report_mismatch("amplitude", out_tdata[AMP_W-1:0], want);
        end
        if (out_tdata[23:AMP_W] !== '0) begin
          report_mismatch("zero fill", AMP_W'(out_tdata[23:AMP_W]), '0);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t rows[$];
    logic [15:0] x, y;
    int sel;
    errors    = 0;
    beats_out = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero angle gives full reflection whatever the absorption
    rows.push_back('{16'h0000, 16'h0000, 1'b1, AMP_ONE});
    rows.push_back('{16'h0000, 16'hFFFF, 1'b1, AMP_ONE});
    rows.push_back('{16'h0000, 16'h1000, 1'b1, AMP_ONE});
    rows.push_back('{16'h0001, 16'h0000, 1'b0, '0});
    rows.push_back('{16'hFFFF, 16'h0000, 1'b0, '0});
    rows.push_back('{16'hFFFF, 16'hFFFF, 1'b0, '0});
    rows.push_back('{16'h0000, 16'h0001, 1'b1, AMP_ONE});
    // critical angle where a is exactly zero, then points around and away from it
    rows.push_back('{16'h1000, 16'h0000, 1'b0, '0});
    rows.push_back('{16'h1000, 16'h0001, 1'b0, '0});
    rows.push_back('{16'h1000, 16'hFFFF, 1'b0, '0});
    rows.push_back('{16'h0FFF, 16'h0000, 1'b0, '0});
    rows.push_back('{16'h1001, 16'h0000, 1'b0, '0});
    rows.push_back('{16'h0800, 16'h0000, 1'b0, '0});
    rows.push_back('{16'h0800, 16'h0100, 1'b0, '0});
    rows.push_back('{16'h2000, 16'h0000, 1'b0, '0});
    rows.push_back('{16'h2000, 16'h2000, 1'b0, '0});
    rows.push_back('{16'h0001, 16'hFFFF, 1'b0, '0});
    rows.push_back('{16'hFFFF, 16'h0001, 1'b0, '0});
    rows.push_back('{16'hAAAA, 16'h5555, 1'b0, '0});
    rows.push_back('{16'h5555, 16'hAAAA, 1'b0, '0});
    foreach (rows[i]) send_beat(rows[i].angle, rows[i].absorb, rows[i].typed, rows[i].amp);

    // random beats, weighted toward the critical angle where the curve bends
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 600) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (amp_queue.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 3);
      case (sel)
        0: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        1: begin
          x = 16'($urandom_range(16'h0800, 16'h1800));
          y = 16'($urandom_range(0, 16'h0200));
        end
        2: begin
          x = 16'($urandom_range(0, 16'h3000));
          y = 16'($urandom_range(0, 16'h1000));
        end
        default: begin
          x = 16'($urandom_range(16'h0F00, 16'h1100));
          y = 16'($urandom);
        end
      endcase
      send_beat(x, y, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // drain and let the pipeline settle
    @(posedge clk);
    while (amp_queue.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
